### rtl/pointer_ballistics_clamp_macros.svh
`ifndef POINTER_BALLISTICS_CLAMP_MACROS_SVH
`define POINTER_BALLISTICS_CLAMP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pbc_pkg.sv
package pbc_pkg;

  localparam int DELTA_W  = 16;
  localparam int THR_W    = 16;
  localparam int GAIN_W   = 4;
  localparam int SCALE_W  = 8;
  localparam int CUR_W    = 12;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 21;
  localparam int MAG_W    = 20;
  localparam int REM_W    = 9;
  localparam int SUMPOS_W = 23;

  localparam int POS_BITS_DEF = 12;

  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int RST_THRESHOLD = 4;
  localparam int RST_GAIN      = 2;
  localparam int RST_SCALE     = 1;
  localparam int RST_WIDTH     = 1024;
  localparam int RST_HEIGHT    = 600;
  localparam int CENTER_DIV    = 2;

  localparam logic [CUR_W-1:0] POS_X_RST = CUR_W'(RST_WIDTH / CENTER_DIV);
  localparam logic [CUR_W-1:0] POS_Y_RST = CUR_W'(RST_HEIGHT / CENTER_DIV);

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_GAIN      = 3'd1,
    REG_SCALE_X   = 3'd2,
    REG_SCALE_Y   = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [GAIN_W-1:0]  gain;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [CUR_W-1:0]   width;
    logic [CUR_W-1:0]   height;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### rtl/pbc_regs.sv
module pbc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pbc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pbc_pkg::DATA_W-1:0]  cfg_data,
  output pbc_pkg::cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= pbc_pkg::THR_W'(pbc_pkg::RST_THRESHOLD);
      cfg.gain      <= pbc_pkg::GAIN_W'(pbc_pkg::RST_GAIN);
      cfg.scale_x   <= pbc_pkg::SCALE_W'(pbc_pkg::RST_SCALE);
      cfg.scale_y   <= pbc_pkg::SCALE_W'(pbc_pkg::RST_SCALE);
      cfg.width     <= pbc_pkg::CUR_W'(pbc_pkg::RST_WIDTH);
      cfg.height    <= pbc_pkg::CUR_W'(pbc_pkg::RST_HEIGHT);
    end else if (cfg_valid) begin
      case (pbc_pkg::reg_idx_t'(cfg_index))
        pbc_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[pbc_pkg::THR_W-1:0];
        pbc_pkg::REG_GAIN:      cfg.gain      <= cfg_data[pbc_pkg::GAIN_W-1:0];
        pbc_pkg::REG_SCALE_X:   cfg.scale_x   <= cfg_data[pbc_pkg::SCALE_W-1:0];
        pbc_pkg::REG_SCALE_Y:   cfg.scale_y   <= cfg_data[pbc_pkg::SCALE_W-1:0];
        pbc_pkg::REG_WIDTH:     cfg.width     <= cfg_data[pbc_pkg::CUR_W-1:0];
        pbc_pkg::REG_HEIGHT:    cfg.height    <= cfg_data[pbc_pkg::CUR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/pbc_ctrl.sv
`include "pointer_ballistics_clamp_macros.svh"

module pbc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbc_pkg::sts_t  sts,
  output pbc_pkg::cmd_t  cmd
);

  localparam logic [pbc_pkg::CNT_W-1:0] LAST = pbc_pkg::CNT_W'(pbc_pkg::DIV_STEPS - 1);

  pbc_pkg::state_t state, state_next;
  logic [pbc_pkg::CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbc_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      pbc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = pbc_pkg::S_PREP;
        end
      end
      pbc_pkg::S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = pbc_pkg::S_LOAD;
      end
      pbc_pkg::S_LOAD: begin
        cmd.load   = 1'b1;
        cnt_next   = '0;
        state_next = pbc_pkg::S_DIV;
      end
      pbc_pkg::S_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = pbc_pkg::S_FIN;
        end
      end
      pbc_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = pbc_pkg::S_IDLE;
        end
      end
      default: state_next = pbc_pkg::S_IDLE;
    endcase
  end

  `PBC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == pbc_pkg::S_PREP && !in_ready, "accepted word did not start work")
  `PBC_ASSERT_NEXT(a_div_ends, state == pbc_pkg::S_DIV && cnt == LAST, state == pbc_pkg::S_FIN, "divide did not end after last step")
  `PBC_ASSERT_NEXT(a_fin_holds, state == pbc_pkg::S_FIN && !sts.out_free, state == pbc_pkg::S_FIN, "result dropped while output busy")

endmodule

### rtl/pbc_dp.sv
`include "pointer_ballistics_clamp_macros.svh"

module pbc_dp #(
  parameter int POS_BITS = pbc_pkg::POS_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pbc_pkg::cfg_t                      cfg,
  input  pbc_pkg::cmd_t                      cmd,
  output pbc_pkg::sts_t                      sts,
  input  logic signed [pbc_pkg::DELTA_W-1:0] delta_x,
  input  logic signed [pbc_pkg::DELTA_W-1:0] delta_y,
  input  logic [pbc_pkg::BYTE_W-1:0]         button_bits,
  input  logic signed [pbc_pkg::BYTE_W-1:0]  wheel_step,
  input  logic signed [pbc_pkg::BYTE_W-1:0]  wheel_side,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pbc_pkg::CUR_W-1:0]          cursor_x,
  output logic [pbc_pkg::CUR_W-1:0]          cursor_y,
  output logic [pbc_pkg::BYTE_W-1:0]         buttons_out,
  output logic signed [pbc_pkg::BYTE_W-1:0]  wheel_out,
  output logic signed [pbc_pkg::BYTE_W-1:0]  wheel_side_out
);

  localparam int CW = pbc_pkg::CUR_W;
  localparam int PW = pbc_pkg::PROD_W;
  localparam int MW = pbc_pkg::MAG_W;
  localparam int RW = pbc_pkg::REM_W;
  localparam int SW = pbc_pkg::SCALE_W;
  localparam int DW = pbc_pkg::DELTA_W;
  localparam int BW = pbc_pkg::BYTE_W;
  localparam int QW = pbc_pkg::SUMPOS_W;
  localparam logic [CW-1:0] PMAX =
    (POS_BITS >= CW) ? {CW{1'b1}} : CW'((1 << POS_BITS) - 1);

  // one restoring step: {quotient bit, new partial remainder}
  function automatic logic [SW:0] div_try(logic [SW-1:0] r, logic qb, logic [SW-1:0] d);
    logic [SW:0] t;
    logic [SW:0] res;
    t = {r, qb};
    if (t >= {1'b0, d}) begin
      res = {1'b1, SW'(t - {1'b0, d})};
    end else begin
      res = {1'b0, t[SW-1:0]};
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] move(logic [CW-1:0] pos, logic neg, logic [MW-1:0] q,
                                         logic [CW-1:0] top);
    logic signed [QW-1:0] qs;
    logic signed [QW-1:0] p;
    logic [CW-1:0] res;
    qs = neg ? -$signed({{(QW-MW){1'b0}}, q}) : $signed({{(QW-MW){1'b0}}, q});
    p  = $signed({{(QW-CW){1'b0}}, pos}) + qs;
    if (p < 0) begin
      res = '0;
    end else if (p > $signed({{(QW-CW){1'b0}}, top})) begin
      res = top;
    end else begin
      res = p[CW-1:0];
    end
    return res;
  endfunction

  logic signed [DW-1:0] dx, dy;
  logic [BW-1:0]        btn;
  logic signed [BW-1:0] wst, wsd;
  logic signed [PW-1:0] prod_x, prod_y;
  logic [MW-1:0]        qx, qy;
  logic [SW-1:0]        rx, ry;
  logic [SW-1:0]        dv_x, dv_y;
  logic                 neg_x, neg_y;
  logic signed [RW-1:0] rem_x, rem_y;
  logic [CW-1:0]        pos_x, pos_y;

  logic [DW:0]          mag_x, mag_y;
  logic [DW+1:0]        mag_sum;
  logic [pbc_pkg::GAIN_W-1:0] g;
  logic signed [PW-1:0] sum_x, sum_y;
  logic [SW:0]          tx, ty;
  logic [CW-1:0]        top_x, top_y;

  assign mag_x   = dx[DW-1] ? -{dx[DW-1], dx} : {dx[DW-1], dx};
  assign mag_y   = dy[DW-1] ? -{dy[DW-1], dy} : {dy[DW-1], dy};
  assign mag_sum = {1'b0, mag_x} + {1'b0, mag_y};
  assign g = (mag_sum > {2'b0, cfg.threshold}) ? cfg.gain : pbc_pkg::GAIN_W'(1);

  assign sum_x = prod_x + {{(PW-RW){rem_x[RW-1]}}, rem_x};
  assign sum_y = prod_y + {{(PW-RW){rem_y[RW-1]}}, rem_y};

  assign tx = div_try(rx, qx[MW-1], dv_x);
  assign ty = div_try(ry, qy[MW-1], dv_y);

  assign top_x = (cfg.width  > PMAX) ? PMAX : cfg.width;
  assign top_y = (cfg.height > PMAX) ? PMAX : cfg.height;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dx  <= delta_x;
      dy  <= delta_y;
      btn <= button_bits;
      wst <= wheel_step;
      wsd <= wheel_side;
    end
    if (cmd.prep) begin
      prod_x <= $signed({{(PW-DW){dx[DW-1]}}, dx}) * $signed({{(PW-pbc_pkg::GAIN_W){1'b0}}, g});
      prod_y <= $signed({{(PW-DW){dy[DW-1]}}, dy}) * $signed({{(PW-pbc_pkg::GAIN_W){1'b0}}, g});
    end
    if (cmd.load) begin
      neg_x <= sum_x[PW-1];
      neg_y <= sum_y[PW-1];
      qx    <= sum_x[PW-1] ? MW'(-sum_x) : MW'(sum_x);
      qy    <= sum_y[PW-1] ? MW'(-sum_y) : MW'(sum_y);
      rx    <= '0;
      ry    <= '0;
      dv_x  <= (cfg.scale_x == '0) ? SW'(1) : cfg.scale_x;
      dv_y  <= (cfg.scale_y == '0) ? SW'(1) : cfg.scale_y;
    end
    if (cmd.step) begin
      qx <= {qx[MW-2:0], tx[SW]};
      qy <= {qy[MW-2:0], ty[SW]};
      rx <= tx[SW-1:0];
      ry <= ty[SW-1:0];
    end
    if (cmd.finish) begin
      buttons_out    <= btn;
      wheel_out      <= wst;
      wheel_side_out <= wsd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= pbc_pkg::POS_X_RST;
      pos_y     <= pbc_pkg::POS_Y_RST;
      rem_x     <= '0;
      rem_y     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        pos_x     <= move(pos_x, neg_x, qx, top_x);
        pos_y     <= move(pos_y, neg_y, qy, top_y);
        rem_x     <= neg_x ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
        rem_y     <= neg_y ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;
  assign cursor_x = pos_x;
  assign cursor_y = pos_y;

  `PBC_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid, "result not presented after finish")
  `PBC_ASSERT_NEXT(a_clamped, cmd.finish, cursor_x <= top_x && cursor_y <= top_y, "cursor outside screen")
  `PBC_ASSERT_NEXT(a_rem_bound, cmd.finish, RW'(rem_x[RW-1] ? -rem_x : rem_x) < {1'b0, dv_x} && RW'(rem_y[RW-1] ? -rem_y : rem_y) < {1'b0, dv_y}, "remainder not below scale")

endmodule

### rtl/pointer_ballistics_clamp.sv
// Mouse report to cursor position with threshold acceleration. A word is
// accepted only while the block is idle, and the next word can be taken once
// the result of the last one is committed. A report passes through capture,
// gain multiply, accumulate, the per-axis remainder divider, which resolves
// one quotient bit per cycle (both axes side by side), and clamp/commit.
// A finished result sits in the output register, so a new report is accepted
// while it waits; the commit of that next report waits until the result is
// taken. The cursor starts at the center of the reset screen (512, 300).
// Registers are written through cfg_index/cfg_data at any time cfg_ready is
// high (always); write them only when the block is idle. A scale of zero acts
// as one; indexes above 5 are ignored.
module pointer_ballistics_clamp #(
  parameter int POS_BITS = pbc_pkg::POS_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pbc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [pbc_pkg::DATA_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pbc_pkg::DELTA_W-1:0] delta_x,
  input  logic signed [pbc_pkg::DELTA_W-1:0] delta_y,
  input  logic [pbc_pkg::BYTE_W-1:0]         button_bits,
  input  logic signed [pbc_pkg::BYTE_W-1:0]  wheel_step,
  input  logic signed [pbc_pkg::BYTE_W-1:0]  wheel_side,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pbc_pkg::CUR_W-1:0]          cursor_x,
  output logic [pbc_pkg::CUR_W-1:0]          cursor_y,
  output logic [pbc_pkg::BYTE_W-1:0]         buttons_out,
  output logic signed [pbc_pkg::BYTE_W-1:0]  wheel_out,
  output logic signed [pbc_pkg::BYTE_W-1:0]  wheel_side_out
);

  pbc_pkg::cfg_t cfg;
  pbc_pkg::cmd_t cmd;
  pbc_pkg::sts_t sts;

  pbc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbc_dp #(
    .POS_BITS (POS_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .delta_x        (delta_x),
    .delta_y        (delta_y),
    .button_bits    (button_bits),
    .wheel_step     (wheel_step),
    .wheel_side     (wheel_side),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_x       (cursor_x),
    .cursor_y       (cursor_y),
    .buttons_out    (buttons_out),
    .wheel_out      (wheel_out),
    .wheel_side_out (wheel_side_out)
  );

endmodule
